// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the tokenizer RTL
// Clocked implication checks with an asynchronous active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/lplt_pkg.sv
// ----------------------------------------------------------------------------
// lplt_pkg
// Types and constants shared by the list tokenizer front, queue and back.
// ----------------------------------------------------------------------------
package lplt_pkg;

	localparam int MAX_DEPTH_DEF = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int NUM_W = 63;

	// Protocol characters.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_OPEN = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5A;

	// Largest accumulator value that can still take one more digit d
	// without passing the 63-bit maximum: (max - d) / 10.
	localparam logic [NUM_W-1:0] ACCUM_MAX = '1;
	localparam logic [NUM_W-1:0] ACCUM_LIMIT_D0_7 = ACCUM_MAX / 10;
	localparam logic [NUM_W-1:0] ACCUM_LIMIT_D8_9 = (ACCUM_MAX - 63'd8) / 10;

	typedef enum logic [2:0] {
		CLS_SEP    = 3'd0,
		CLS_OPEN   = 3'd1,
		CLS_CLOSE  = 3'd2,
		CLS_DIGIT  = 3'd3,
		CLS_LETTER = 3'd4,
		CLS_COLON  = 3'd5,
		CLS_DASH   = 3'd6,
		CLS_OTHER  = 3'd7
	} cls_t;

	typedef struct packed {
		logic [7:0] data;
		cls_t       cls;
	} entry_t;

	typedef enum logic [2:0] {
		KIND_OPEN      = 3'd0,
		KIND_CLOSE     = 3'd1,
		KIND_NUMBER    = 3'd2,
		KIND_STR_START = 3'd3,
		KIND_STR_BYTE  = 3'd4,
		KIND_WORD_BYTE = 3'd5,
		KIND_WORD_END  = 3'd6,
		KIND_ERROR     = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_BAD_CHAR    = 3'd1,
		ERR_NUM_OVF     = 3'd2,
		ERR_DEPTH_OVF   = 3'd3,
		ERR_CLOSE_ZERO  = 3'd4
	} err_t;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_NUM  = 4'b0010,
		MODE_STR  = 4'b0100,
		MODE_WORD = 4'b1000
	} mode_t;

endpackage

// File: rtl/lplt_front.sv
// ----------------------------------------------------------------------------
// lplt_front
// Accepts raw bytes and tags each with its character class for the back end.
// ----------------------------------------------------------------------------
module lplt_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	output logic             push,
	output lplt_pkg::entry_t push_entry,
	input  logic             queue_full
);
	import lplt_pkg::*;

	cls_t cls;

	always_comb begin
		priority if (in_byte == CH_SPACE || in_byte == CH_NEWLINE) begin
			cls = CLS_SEP;
		end else if (in_byte == CH_OPEN) begin
			cls = CLS_OPEN;
		end else if (in_byte == CH_CLOSE) begin
			cls = CLS_CLOSE;
		end else if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
			cls = CLS_DIGIT;
		end else if ((in_byte >= CH_LOW_A && in_byte <= CH_LOW_Z) ||
				(in_byte >= CH_UP_A && in_byte <= CH_UP_Z)) begin
			cls = CLS_LETTER;
		end else if (in_byte == CH_COLON) begin
			cls = CLS_COLON;
		end else if (in_byte == CH_DASH) begin
			cls = CLS_DASH;
		end else begin
			cls = CLS_OTHER;
		end
	end

	assign in_ready = !queue_full;
	assign push = in_valid && !queue_full;
	assign push_entry.data = in_byte;
	assign push_entry.cls = cls;

endmodule

// File: rtl/lplt_queue.sv
// ----------------------------------------------------------------------------
// lplt_queue
// Short first-in first-out buffer of classified bytes between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lplt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lplt_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output lplt_pkg::entry_t head
);
	import lplt_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t        entries_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = entries_q[rd_ptr_q];
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	`ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH))
	`ASSERT_NEXT(a_push_only_grows, clk, arst_n, push && !do_pop, count_q != '0)

endmodule

// File: rtl/lplt_back.sv
// ----------------------------------------------------------------------------
// lplt_back
// Token state machine: consumes classified bytes and drives the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lplt_back #(
	parameter int MAX_DEPTH = lplt_pkg::MAX_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_not_empty,
	input  lplt_pkg::entry_t             q_head,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   token_kind,
	output logic [lplt_pkg::NUM_W-1:0]   num_value,
	output logic [7:0]                   data_byte,
	output logic                         string_end,
	output logic [6:0]                   nest_depth,
	output logic [2:0]                   error_code,
	output logic                         last_of_run
);
	import lplt_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);

	mode_t            mode_q, mode_n;
	logic [NUM_W-1:0] accum_q, accum_n;
	logic [NUM_W-1:0] remain_q, remain_n;
	logic [DW-1:0]    depth_q, depth_n;
	logic [DW+6:0]    depth_ext;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [NUM_W-1:0] num_q;
	logic [7:0]       data_q;
	logic             send_q;
	logic [6:0]       nest_q;
	err_t             err_q;
	logic             last_q;

	logic             advance, fire, emit, pop;
	kind_t            r_kind;
	logic [NUM_W-1:0] r_num;
	logic [7:0]       r_data;
	logic             r_send;
	err_t             r_err;
	logic             r_last;

	logic [7:0]       digit_full;
	logic [3:0]       digit;
	logic [NUM_W-1:0] limit;
	logic [NUM_W-1:0] accum_x10;

	assign advance = !out_valid_q || out_ready;
	assign fire = q_not_empty && advance;
	assign q_pop = fire && pop;

	assign digit_full = q_head.data - CH_ZERO;
	assign digit = digit_full[3:0];
	assign limit = (digit <= 4'd7) ? ACCUM_LIMIT_D0_7 : ACCUM_LIMIT_D8_9;
	assign accum_x10 = {accum_q[NUM_W-4:0], 3'b000} + {accum_q[NUM_W-2:0], 1'b0}
		+ NUM_W'(digit);

	always_comb begin
		mode_n = mode_q;
		accum_n = accum_q;
		remain_n = remain_q;
		depth_n = depth_q;
		emit = 1'b0;
		pop = 1'b1;
		r_kind = KIND_OPEN;
		r_num = '0;
		r_data = '0;
		r_send = 1'b0;
		r_err = ERR_NONE;
		r_last = 1'b1;
		unique case (mode_q)
			MODE_IDLE: begin
				unique case (q_head.cls)
					CLS_SEP: begin
						emit = 1'b0;
					end
					CLS_OPEN: begin
						emit = 1'b1;
						if (depth_q >= DW'(MAX_DEPTH)) begin
							r_kind = KIND_ERROR;
							r_err = ERR_DEPTH_OVF;
						end else begin
							depth_n = depth_q + 1'b1;
						end
					end
					CLS_CLOSE: begin
						emit = 1'b1;
						if (depth_q == '0) begin
							r_kind = KIND_ERROR;
							r_err = ERR_CLOSE_ZERO;
						end else begin
							r_kind = KIND_CLOSE;
							depth_n = depth_q - 1'b1;
						end
					end
					CLS_DIGIT: begin
						accum_n = NUM_W'(digit);
						mode_n = MODE_NUM;
					end
					CLS_LETTER: begin
						emit = 1'b1;
						r_kind = KIND_WORD_BYTE;
						r_data = q_head.data;
						mode_n = MODE_WORD;
					end
					default: begin
						emit = 1'b1;
						r_kind = KIND_ERROR;
						r_err = ERR_BAD_CHAR;
					end
				endcase
			end
			MODE_NUM: begin
				emit = 1'b1;
				priority if (q_head.cls == CLS_DIGIT) begin
					if (accum_q > limit) begin
						r_kind = KIND_ERROR;
						r_err = ERR_NUM_OVF;
						accum_n = '0;
						mode_n = MODE_IDLE;
					end else begin
						emit = 1'b0;
						accum_n = accum_x10;
					end
				end else if (q_head.cls == CLS_COLON) begin
					r_kind = KIND_STR_START;
					accum_n = '0;
					if (accum_q == '0) begin
						r_send = 1'b1;
						mode_n = MODE_IDLE;
					end else begin
						r_num = accum_q;
						remain_n = accum_q;
						mode_n = MODE_STR;
					end
				end else begin
					// A terminating byte other than a separator stays at the queue head and is
					// handled again, in idle mode, as the first byte after the number.
					r_kind = KIND_NUMBER;
					r_num = accum_q;
					accum_n = '0;
					mode_n = MODE_IDLE;
					r_last = (q_head.cls == CLS_SEP);
					pop = (q_head.cls == CLS_SEP);
				end
			end
			MODE_STR: begin
				emit = 1'b1;
				r_kind = KIND_STR_BYTE;
				r_data = q_head.data;
				remain_n = (remain_q == '0) ? '0 : remain_q - 1'b1;
				if (remain_q <= NUM_W'(1)) begin
					r_send = 1'b1;
					mode_n = MODE_IDLE;
				end
			end
			MODE_WORD: begin
				emit = 1'b1;
				if (q_head.cls == CLS_LETTER || q_head.cls == CLS_DIGIT ||
						q_head.cls == CLS_DASH) begin
					r_kind = KIND_WORD_BYTE;
					r_data = q_head.data;
				end else begin
					r_kind = KIND_WORD_END;
					mode_n = MODE_IDLE;
					r_last = (q_head.cls == CLS_SEP);
					pop = (q_head.cls == CLS_SEP);
				end
			end
			default: begin
				mode_n = MODE_IDLE;
			end
		endcase
	end

	assign depth_ext = {7'b0, depth_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			accum_q <= '0;
			remain_q <= '0;
			depth_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				mode_q <= mode_n;
				accum_q <= accum_n;
				remain_q <= remain_n;
				depth_q <= depth_n;
			end
			if (advance) begin
				out_valid_q <= fire && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q <= r_kind;
			num_q <= r_num;
			data_q <= r_data;
			send_q <= r_send;
			nest_q <= depth_ext[6:0];
			err_q <= r_err;
			last_q <= r_last;
		end
	end

	assign out_valid = out_valid_q;
	assign token_kind = kind_q;
	assign num_value = num_q;
	assign data_byte = data_q;
	assign string_end = send_q;
	assign nest_depth = nest_q;
	assign error_code = err_q;
	assign last_of_run = last_q;

	`ASSERT_SAME(a_depth_bound, clk, arst_n, 1'b1, depth_q <= DW'(MAX_DEPTH))
	`ASSERT_SAME(a_str_nonzero, clk, arst_n, mode_q == MODE_STR, remain_q != '0)
	`ASSERT_SAME(a_err_only_on_error, clk, arst_n, out_valid_q && kind_q != KIND_ERROR, err_q == ERR_NONE)
	`ASSERT_NEXT(a_held_byte_goes_idle, clk, arst_n, fire && !pop, mode_q == MODE_IDLE && !last_of_run)

endmodule

// File: rtl/length_prefixed_list_tokenizer.sv
// ----------------------------------------------------------------------------
// length_prefixed_list_tokenizer
// Byte-wide tokenizer for a list-structured, length-prefixed wire protocol.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    in_byte
//   out      output     out_valid / out_ready  token_kind, num_value, data_byte,
//                                               string_end, nest_depth,
//                                               error_code, last_of_run
//
// A byte that terminates a number or a word and is not a separator passes
// through the back end twice, since it then yields two tokens through the
// single result register, which takes one transaction per cycle when not
// stalled. Reset clears the token mode, the accumulators,
// the depth counter and the queue; no clearing pass is needed. The input side
// stalls only when the four-entry queue is full, and the back end stalls only
// while the result register holds a transaction that has not been taken.
//
module length_prefixed_list_tokenizer #(
	parameter int MAX_DEPTH = lplt_pkg::MAX_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  in_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  token_kind,
	output logic [lplt_pkg::NUM_W-1:0]  num_value,
	output logic [7:0]                  data_byte,
	output logic                        string_end,
	output logic [6:0]                  nest_depth,
	output logic [2:0]                  error_code,
	output logic                        last_of_run
);
	import lplt_pkg::*;

	// Front end: classify each incoming byte and push it into the queue.
	logic   push;
	entry_t push_entry;
	logic   queue_full;

	// Queue to back end.
	logic   q_not_empty;
	entry_t q_head;
	logic   q_pop;

	lplt_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (queue_full)
	);

	// The queue decouples the byte stream from token emission, so input keeps
	// flowing while the back end handles a terminator byte a second time.
	lplt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	// Back end: token state machine, number accumulator, string counter,
	// nesting depth and the registered result transaction.
	lplt_back #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.num_value   (num_value),
		.data_byte   (data_byte),
		.string_end  (string_end),
		.nest_depth  (nest_depth),
		.error_code  (error_code),
		.last_of_run (last_of_run)
	);

endmodule
